// ===== hw/rtl/rrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrfc_pkg
// Shared types and constants of the receive ring buffer with test detector.
// ----------------------------------------------------------------------------
package rrfc_pkg;

  // Default ring depth; the ring holds at most one word fewer than this.
  localparam int unsigned DefaultDepth = 256;

  // Run counter saturation point and trigger reset value.
  localparam logic [7:0] RunLimit     = 8'd200;
  localparam logic [7:0] TriggerReset = 8'd60;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgCmdByte   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTrigCount = 2'd1;

  // Operation codes. Codes five to seven do nothing.
  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_MARK   = 3'd2,
    OP_REWIND = 3'd3,
    OP_QUERY  = 3'd4
  } op_e;

  // Per-word control carried from the pointer stage to the result stage.
  typedef struct packed {
    logic active;    // a word was accepted in the previous cycle
    logic pop_hit;   // pop found data; read data arrives with this stage
    logic query;     // test query
    logic overflow;  // push found the ring full
  } stage_t;

endpackage

// ===== hw/rtl/rrfc_ram.sv =====
// ----------------------------------------------------------------------------
// rrfc_ram
// Byte store of the ring: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rrfc_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rrfc_ptr.sv =====
// ----------------------------------------------------------------------------
// rrfc_ptr
// Ring pointers: write, read and saved read pointer, full/empty decisions.
// ----------------------------------------------------------------------------
module rrfc_ptr
  import rrfc_pkg::*;
#(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [2:0]       op_i,
  output logic             we_o,
  output logic [AddrW-1:0] waddr_o,
  output logic             re_o,
  output logic [AddrW-1:0] raddr_o,
  output stage_t           stage_o
);

  localparam logic [AddrW-1:0] LastSlot = AddrW'(Depth - 1);

  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AddrW-1:0] mark_q, mark_d;
  stage_t           stage_q, stage_d;
  logic [AddrW-1:0] wr_next, rd_next;
  logic             full, empty;

  assign wr_next = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
  assign full    = (wr_next == rd_ptr_q);
  assign empty   = (rd_ptr_q == wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    mark_d   = mark_q;
    stage_d  = '0;
    we_o     = 1'b0;
    re_o     = 1'b0;
    if (accept_i) begin
      stage_d.active = 1'b1;
      case (op_e'(op_i))
        OP_PUSH: begin
          if (full) begin
            stage_d.overflow = 1'b1;
          end else begin
            we_o     = 1'b1;
            wr_ptr_d = wr_next;
          end
        end
        OP_POP: begin
          if (!empty) begin
            re_o            = 1'b1;
            stage_d.pop_hit = 1'b1;
            rd_ptr_d        = rd_next;
          end
        end
        OP_MARK: begin
          mark_d = rd_ptr_q;
        end
        OP_REWIND: begin
          rd_ptr_d = mark_q;
        end
        OP_QUERY: begin
          stage_d.query = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      mark_q   <= '0;
      stage_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      mark_q   <= mark_d;
      stage_q  <= stage_d;
    end
  end

  assign waddr_o = wr_ptr_q;
  assign raddr_o = rd_ptr_q;
  assign stage_o = stage_q;

  // A single word never both writes and reads the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(we_o && re_o))
    else $error("store written and read by the same word");

  // Every accepted word reaches the result stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept_i |=> stage_q.active)
    else $error("accepted word lost before result stage");

  // A dropped push leaves the write pointer where it was.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   stage_q.overflow |-> wr_ptr_q == $past(wr_ptr_q))
    else $error("write pointer moved on overflow");

endmodule

// ===== hw/rtl/rrfc_run.sv =====
// ----------------------------------------------------------------------------
// rrfc_run
// Configuration registers, command run counter and result register.
// ----------------------------------------------------------------------------
module rrfc_run
  import rrfc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  stage_t              stage_i,
  input  logic [7:0]          rdata_i,
  output logic                done_o,
  output logic                data_valid_o,
  output logic [7:0]          data_out_o,
  output logic                overflow_o,
  output logic                test_detected_o
);

  logic [7:0] cmd_byte_q;
  logic [7:0] trig_cnt_q;
  logic [7:0] run_cnt_q, run_cnt_d;
  logic [7:0] run_inc;
  logic       hit_d;
  logic       done_q, valid_q, ovf_q, det_q;
  logic [7:0] dout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_byte_q <= '0;
      trig_cnt_q <= TriggerReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCmdByte:   cmd_byte_q <= cfg_wdata_i;
        CfgTrigCount: trig_cnt_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign run_inc = run_cnt_q + 8'd1;

  always_comb begin
    run_cnt_d = run_cnt_q;
    hit_d     = 1'b0;
    if (stage_i.pop_hit) begin
      if (rdata_i == cmd_byte_q) begin
        run_cnt_d = (run_inc >= RunLimit) ? RunLimit : run_inc;
      end else begin
        run_cnt_d = '0;
      end
    end else if (stage_i.query && (run_cnt_q == trig_cnt_q)) begin
      run_cnt_d = run_inc;
      hit_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_cnt_q <= '0;
      done_q    <= 1'b0;
      valid_q   <= 1'b0;
      ovf_q     <= 1'b0;
      det_q     <= 1'b0;
      dout_q    <= '0;
    end else begin
      run_cnt_q <= run_cnt_d;
      done_q    <= stage_i.active;
      valid_q   <= stage_i.pop_hit;
      ovf_q     <= stage_i.overflow;
      det_q     <= hit_d;
      dout_q    <= stage_i.pop_hit ? rdata_i : '0;
    end
  end

  assign done_o          = done_q;
  assign data_valid_o    = valid_q;
  assign data_out_o      = dout_q;
  assign overflow_o      = ovf_q;
  assign test_detected_o = det_q;

  // Result flags only appear together with the strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (valid_q || ovf_q || det_q) |-> done_q)
    else $error("result flag without strobe");

  // The run count stays at most one above its saturation point.
  assert property (@(posedge clk_i) disable iff (!rst_ni) run_cnt_q <= RunLimit + 8'd1)
    else $error("run count beyond limit");

  // A detection always moves the run count on by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   det_q |-> run_cnt_q == $past(run_cnt_q) + 8'd1)
    else $error("detection without run count step");

endmodule

// ===== hw/rtl/rx_ring_fifo_rewind_cmd_detect_top.sv =====
// ----------------------------------------------------------------------------
// rx_ring_fifo_rewind_cmd_detect_top
// Receive byte ring with mark/rewind of the read pointer and a detector for a
// repeated test command byte.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   -----------------------------------
//   command   start, busy (always low)  op_i, data_in_i
//   result    done_o (one-cycle pulse)  data_valid_o, data_out_o,
//                                       overflow_o, test_detected_o
//   config    cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One word is accepted in every cycle in which start is high; busy never
// rises. The result of a word is on the result ports, with done_o high, once
// the result register holds it, and is taken at the edge after that: the
// accept edge updates the pointers and reads the byte store, the edge after
// it updates the run counter from the registered read data and loads the
// result register. The receiver cannot stall, so results are never held.
// Reset clears the pointers, the run count and the command byte, sets the
// trigger count to its reset value and leaves the byte store uncleared.
//
module rx_ring_fifo_rewind_cmd_detect_top
  import rrfc_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          op_i,
  input  logic [7:0]          data_in_i,
  output logic                done_o,
  output logic                data_valid_o,
  output logic [7:0]          data_out_o,
  output logic                overflow_o,
  output logic                test_detected_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // Pointer width follows the ring depth; a depth that is not a power of two
  // wraps explicitly at the last slot.
  localparam int unsigned AddrW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic             accept;
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [7:0]       rdata;
  stage_t           stage;

  // Every operation finishes in a fixed two-stage path, so the block is never
  // busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // The pointer stage decides full and empty and drives the store ports.
  rrfc_ptr #(
    .Depth (BUFFER_DEPTH),
    .AddrW (AddrW)
  ) u_ptr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (op_i),
    .we_o     (we),
    .waddr_o  (waddr),
    .re_o     (re),
    .raddr_o  (raddr),
    .stage_o  (stage)
  );

  // The pushed word is written in the cycle it is accepted; a pop reads its
  // byte into the store's output register in the same cycle.
  rrfc_ram #(
    .Depth (BUFFER_DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_in_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // The result stage sees the popped byte and keeps the run count in order
  // with test queries, since both act in this stage only.
  rrfc_run u_run (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .stage_i         (stage),
    .rdata_i         (rdata),
    .done_o          (done_o),
    .data_valid_o    (data_valid_o),
    .data_out_o      (data_out_o),
    .overflow_o      (overflow_o),
    .test_detected_o (test_detected_o)
  );

endmodule

// ===== tb/rx_ring_fifo_rewind_cmd_detect_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rx_ring_fifo_rewind_cmd_detect_top_tb
// Self-checking bench for the receive byte ring with mark/rewind and the
// repeated test command detector. A directed table is walked first, then
// random sequences of pushes, pops, marks, rewinds and test queries are sent
// under several register settings, and every result word not fixed in the
// table is compared with a behavioral copy of the ring kept inside the bench.
// ----------------------------------------------------------------------------
module rx_ring_fifo_rewind_cmd_detect_top_tb;
  import rrfc_pkg::*;

  // The bench and the block share one ring depth. A result word trails its
  // command word by ResultLat, and twice that is allowed to settle before a
  // register write or the end of the run.
  localparam int unsigned Depth        = DefaultDepth;
  localparam int unsigned ResultLat    = 2;
  localparam int unsigned SettleCycles = 2 * ResultLat;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned NumRows      = 26;

  // Operation codes that the block must ignore.
  localparam logic [2:0] OpSpare5 = 3'd5;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  // Register indexes beyond the two real registers; writes there are dropped.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_out;
    logic       overflow;
    logic       test_detected;
  } result_t;

  localparam result_t Quiet = '0;

  // A directed row is either a word checked against the ring copy, a word
  // whose result is written into the table, or a register write.
  typedef enum logic [1:0] {
    RowWord  = 2'd0,
    RowFixed = 2'd1,
    RowCfg   = 2'd2
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [2:0]         op;
    logic [7:0]         data;
    logic [CfgIdxW-1:0] cfg_idx;
    result_t            res;
  } step_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [2:0]          op_i;
  logic [7:0]          data_in_i;
  logic                done_o;
  logic                data_valid_o;
  logic [7:0]          data_out_o;
  logic                overflow_o;
  logic                test_detected_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // Travels with start so that the checker knows whether the word being
  // taken carries a result written into the table.
  logic    row_fixed;
  result_t row_fixed_res;

  rx_ring_fifo_rewind_cmd_detect_top #(
    .BUFFER_DEPTH(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .data_in_i      (data_in_i),
    .done_o         (done_o),
    .data_valid_o   (data_valid_o),
    .data_out_o     (data_out_o),
    .overflow_o     (overflow_o),
    .test_detected_o(test_detected_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Behavioral copy of the ring, its pointers, the run counter and the two
  // registers. It is advanced once for every word the block takes.
  // --------------------------------------------------------------------------
  logic [7:0]  ring_mem [Depth];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  int unsigned mark_ptr;
  logic [7:0]  cmd_run;
  logic [7:0]  cmd_byte;
  logic [7:0]  trig_count;

  result_t awaited_results [$];
  int      error_count;
  int      words_sent;
  int      stall_cycles;

  // Sender pacing: percent chance of an idle cycle before each word, and a
  // flag that switches idling off for a stretch.
  int idle_pct;
  bit burst_mode;

  function automatic int unsigned next_slot(int unsigned i);
    return (i + 1 >= Depth) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_fill();
    return (wr_ptr + Depth - rd_ptr) % Depth;
  endfunction

  // Applies one operation to the ring copy and returns the result word the
  // block should produce for it.
  function automatic result_t ring_op_result(logic [2:0] op, logic [7:0] din);
    result_t     r;
    int unsigned nxt;
    r = Quiet;
    case (op)
      OP_PUSH: begin
        nxt = next_slot(wr_ptr);
        // One slot always stays free; a push into a full ring is dropped.
        if (nxt == rd_ptr) begin
          r.overflow = 1'b1;
        end else begin
          ring_mem[wr_ptr] = din;
          wr_ptr = nxt;
        end
      end
      OP_POP: begin
        // A pop on an empty ring returns nothing and leaves the run alone.
        if (rd_ptr != wr_ptr) begin
          r.data_valid = 1'b1;
          r.data_out   = ring_mem[rd_ptr];
          rd_ptr       = next_slot(rd_ptr);
          if (r.data_out == cmd_byte) begin
            cmd_run = cmd_run + 8'd1;
            if (cmd_run >= RunLimit) cmd_run = RunLimit;
          end else begin
            cmd_run = 8'd0;
          end
        end
      end
      OP_MARK: mark_ptr = rd_ptr;
      OP_REWIND: rd_ptr = mark_ptr;
      OP_QUERY: begin
        // A hit bumps the run past the trigger so that it reports only once.
        if (cmd_run == trig_count) begin
          cmd_run         = cmd_run + 8'd1;
          r.test_detected = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void log_mismatch(string what, result_t want, result_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch at %0t: %s; expected valid=%0b data=%02h ovf=%0b det=%0b,",
               $realtime, what, want.data_valid, want.data_out, want.overflow,
               want.test_detected);
      $display("  got valid=%0b data=%02h ovf=%0b det=%0b",
               got.data_valid, got.data_out, got.overflow, got.test_detected);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checker. All ports are sampled at the rising edge, so the values seen are
  // the ones that stood during the cycle the edge ends. A result is checked
  // before the word taken at the same edge is predicted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_and_predict
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        got = {data_valid_o, data_out_o, overflow_o, test_detected_o};
        if (awaited_results.size() == 0) begin
          log_mismatch("result word with nothing awaited", Quiet, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.data_valid !== want.data_valid || got.data_out !== want.data_out ||
              got.overflow !== want.overflow || got.test_detected !== want.test_detected) begin
            log_mismatch("result word differs", want, got);
          end
        end
      end
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          CfgCmdByte:   cmd_byte   = cfg_wdata_i;
          CfgTrigCount: trig_count = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start && busy === 1'b0) begin
        want = ring_op_result(op_i, data_in_i);
        if (row_fixed) want = row_fixed_res;
        awaited_results.push_back(want);
      end
    end
  end

  // Cycles in which nothing moves on any port. The watchdog below ends the
  // run once this count gets too high.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && busy === 1'b0) || done_o === 1'b1 || cfg_we_i === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("rx_ring_fifo_rewind_cmd_detect_top_tb: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Every input changes only by nonblocking assignment right
  // after a rising edge, and start gets at most one assignment per edge.
  // --------------------------------------------------------------------------

  // Sends one command word and returns once the block has taken it. While
  // start is low the payload carries random noise that must be ignored.
  task automatic send_word(logic [2:0] op, logic [7:0] din, bit fixed = 1'b0,
                           result_t fixed_res = Quiet);
    if (!burst_mode) begin
      while ($urandom_range(0, 99) < idle_pct) begin
        start     <= 1'b0;
        op_i      <= 3'($urandom);
        data_in_i <= 8'($urandom);
        @(posedge clk_i);
      end
    end
    start         <= 1'b1;
    op_i          <= op;
    data_in_i     <= din;
    row_fixed     <= fixed;
    row_fixed_res <= fixed_res;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    words_sent++;
  endtask

  // Stops sending and waits until every awaited result word has come back,
  // then lets the pipeline drain a little longer.
  task automatic wait_idle();
    start     <= 1'b0;
    op_i      <= 3'($urandom);
    data_in_i <= 8'($urandom);
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write. Only called while the block is idle. The enable is
  // lowered at the next edge so that back-to-back writes never assign it twice
  // at one edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgIdxW'($urandom);
    cfg_wdata_i <= CfgDataW'($urandom);
    @(posedge clk_i);
  endtask

  // Pushes a short run of bytes, mostly the command byte, then pops them
  // back with queries scattered in between, so small triggers get hit.
  task automatic run_of_cmd();
    int         k;
    logic [7:0] b;
    k = $urandom_range(1, 12);
    repeat (k) begin
      b = ($urandom_range(0, 7) != 0) ? cmd_byte : 8'($urandom);
      send_word(OP_PUSH, b);
    end
    repeat (k + $urandom_range(0, 2)) begin
      send_word(OP_POP, 8'($urandom));
      if ($urandom_range(0, 9) < 3) send_word(OP_QUERY, 8'($urandom));
    end
    send_word(OP_QUERY, 8'($urandom));
  endtask

  // Marks, reads ahead, rewinds and reads the same bytes again. Sometimes
  // bytes are pushed between the mark and the rewind.
  task automatic mark_and_replay();
    int j;
    j = $urandom_range(1, 10);
    send_word(OP_MARK, 8'($urandom));
    repeat (j) send_word(OP_POP, 8'($urandom));
    send_word(OP_QUERY, 8'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) send_word(OP_PUSH, 8'($urandom));
    end
    send_word(OP_REWIND, 8'($urandom));
    repeat (j) send_word(OP_POP, 8'($urandom));
    send_word(OP_QUERY, 8'($urandom));
  endtask

  // A few words with any op code, the unused ones included.
  task automatic noise_burst();
    repeat ($urandom_range(1, 8)) send_word(3'($urandom_range(0, 7)), 8'($urandom));
  endtask

  task automatic run_mixed(int target);
    int pick;
    while (words_sent < target) begin
      burst_mode = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        run_of_cmd();
      end else if (pick < 65) begin
        mark_and_replay();
      end else begin
        noise_burst();
      end
    end
    burst_mode = 1'b0;
  endtask

  // Drives the run counter all the way to its saturation point: the ring is
  // emptied, filled with command bytes and replayed by rewinding until well
  // over two hundred matching bytes have been popped in a row.
  task automatic saturate_run();
    int n;
    wait_idle();
    n = ring_fill();
    repeat (n) send_word(OP_POP, 8'($urandom));
    repeat (36) send_word(OP_PUSH, cmd_byte);
    send_word(OP_MARK, 8'($urandom));
    repeat (6) begin
      repeat (36) begin
        send_word(OP_POP, 8'($urandom));
        if ($urandom_range(0, 2) == 0) send_word(OP_QUERY, 8'($urandom));
      end
      send_word(OP_QUERY, 8'($urandom));
      send_word(OP_REWIND, 8'($urandom));
    end
  endtask

  // With the run saturated and the trigger at the limit, a hit lifts the
  // count one past the limit and the next matching pop brings it back.
  task automatic hold_at_limit();
    repeat (6) begin
      send_word(OP_QUERY, 8'($urandom));
      send_word(OP_POP, 8'($urandom));
      if ($urandom_range(0, 1) == 1) send_word(OP_QUERY, 8'($urandom));
    end
    send_word(OP_REWIND, 8'($urandom));
  endtask

  // Fills the ring and keeps pushing so that several bytes are dropped.
  task automatic fill_past_full();
    int n;
    wait_idle();
    n = Depth - 1 - ring_fill() + $urandom_range(2, 5);
    repeat (n) send_word(OP_PUSH, 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Results are written in only where they follow directly
  // from reset, the extremes or the empty ring; the other rows are checked
  // against the ring copy.
  // --------------------------------------------------------------------------
  step_row_t directed_plan [NumRows];

  initial begin
    directed_plan = '{
      // Empty ring right after reset: the pop returns nothing.
      '{RowFixed, OP_POP,    8'h00, CfgCmdByte,   Quiet},
      // Run count zero, trigger at its reset value: no detection.
      '{RowFixed, OP_QUERY,  8'hFF, CfgCmdByte,   Quiet},
      // The unused op codes do nothing at all.
      '{RowFixed, OpSpare5,  8'h5A, CfgCmdByte,   Quiet},
      '{RowFixed, OpSpare6,  8'hA5, CfgCmdByte,   Quiet},
      '{RowFixed, OpSpare7,  8'hFF, CfgCmdByte,   Quiet},
      '{RowFixed, OP_PUSH,   8'h00, CfgCmdByte,   Quiet},
      '{RowFixed, OP_PUSH,   8'hFF, CfgCmdByte,   Quiet},
      '{RowFixed, OP_PUSH,   8'hA5, CfgCmdByte,   Quiet},
      '{RowFixed, OP_MARK,   8'h00, CfgCmdByte,   Quiet},
      '{RowFixed, OP_POP,    8'h00, CfgCmdByte,   '{1'b1, 8'h00, 1'b0, 1'b0}},
      '{RowFixed, OP_POP,    8'h00, CfgCmdByte,   '{1'b1, 8'hFF, 1'b0, 1'b0}},
      '{RowFixed, OP_POP,    8'h00, CfgCmdByte,   '{1'b1, 8'hA5, 1'b0, 1'b0}},
      '{RowFixed, OP_POP,    8'hFF, CfgCmdByte,   Quiet},
      // Rewind to the mark and read the first byte once more.
      '{RowFixed, OP_REWIND, 8'h00, CfgCmdByte,   Quiet},
      '{RowFixed, OP_POP,    8'h00, CfgCmdByte,   '{1'b1, 8'h00, 1'b0, 1'b0}},
      '{RowCfg,   OP_PUSH,   8'd0,  CfgTrigCount, Quiet},
      '{RowWord,  OP_QUERY,  8'h00, CfgCmdByte,   Quiet},
      '{RowCfg,   OP_PUSH,   8'hFF, CfgCmdByte,   Quiet},
      '{RowWord,  OP_POP,    8'h00, CfgCmdByte,   Quiet},
      '{RowWord,  OP_POP,    8'h00, CfgCmdByte,   Quiet},
      // Trigger zero with the run just broken: the query hits, then not again.
      '{RowWord,  OP_QUERY,  8'h00, CfgCmdByte,   Quiet},
      '{RowWord,  OP_QUERY,  8'h00, CfgCmdByte,   Quiet},
      // Writes to the unused register indexes must change nothing.
      '{RowCfg,   OP_PUSH,   8'h55, CfgSpareA,    Quiet},
      '{RowCfg,   OP_PUSH,   8'hAA, CfgSpareB,    Quiet},
      // A trigger above the run limit can never be reached.
      '{RowCfg,   OP_PUSH,   8'hFF, CfgTrigCount, Quiet},
      '{RowWord,  OP_QUERY,  8'h00, CfgCmdByte,   Quiet}
    };
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    start         = 1'b0;
    op_i          = OP_PUSH;
    data_in_i     = 8'h00;
    row_fixed     = 1'b0;
    row_fixed_res = Quiet;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgCmdByte;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    words_sent    = 0;
    idle_pct      = 35;
    burst_mode    = 1'b0;
    wr_ptr        = 0;
    rd_ptr        = 0;
    mark_ptr      = 0;
    cmd_run       = 8'd0;
    cmd_byte      = 8'd0;
    trig_count    = TriggerReset;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      if (directed_plan[r].kind == RowCfg) begin
        wait_idle();
        write_reg(directed_plan[r].cfg_idx, directed_plan[r].data);
      end else begin
        send_word(directed_plan[r].op, directed_plan[r].data,
                  directed_plan[r].kind == RowFixed, directed_plan[r].res);
      end
    end

    // Sender idles often; a random command byte and a small trigger so that
    // short runs of the command byte are detected.
    wait_idle();
    write_reg(CfgCmdByte, 8'($urandom));
    write_reg(CfgTrigCount, 8'($urandom_range(0, 12)));
    run_mixed(300);

    // Sender idles most of the time. The run is pushed to saturation with the
    // trigger just below the limit, then held there with the trigger at it.
    idle_pct = 75;
    wait_idle();
    write_reg(CfgCmdByte, 8'hFF);
    write_reg(CfgTrigCount, 8'd199);
    saturate_run();
    wait_idle();
    write_reg(CfgTrigCount, RunLimit);
    hold_at_limit();
    wait_idle();
    write_reg(CfgTrigCount, 8'($urandom_range(0, 8)));
    run_mixed(700);

    // Sender never idles: a word every cycle. The ring is run into overflow,
    // partly drained, and then mixed traffic continues near full.
    idle_pct = 0;
    wait_idle();
    write_reg(CfgCmdByte, 8'h00);
    write_reg(CfgTrigCount, 8'($urandom_range(1, 10)));
    fill_past_full();
    repeat ($urandom_range(40, 100)) begin
      send_word(OP_POP, 8'($urandom));
      if ($urandom_range(0, 3) == 0) send_word(OP_QUERY, 8'($urandom));
    end
    run_mixed(1050);

    wait_idle();
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("rx_ring_fifo_rewind_cmd_detect_top_tb: clean");
    end else begin
      $display("rx_ring_fifo_rewind_cmd_detect_top_tb: errors");
    end
    $finish;
  end

endmodule
